### rtl/xdcd_pkg.sv
// Shared types and constants for the XOR-delta command decoder.
`default_nettype none

package xdcd_pkg;

  // Decoder phase, one-hot.
  typedef enum logic [6:0] {
    PH_CMD      = 7'b0000001,
    PH_SF_COUNT = 7'b0000010,
    PH_SF_VALUE = 7'b0000100,
    PH_LONG_LO  = 7'b0001000,
    PH_LONG_HI  = 7'b0010000,
    PH_LF_VALUE = 7'b0100000,
    PH_LIT      = 7'b1000000
  } phase_t;

  // Action codes.
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_SKIP = 2'd1;
  localparam logic [1:0] ACT_FILL = 2'd2;
  localparam logic [1:0] ACT_LIT  = 2'd3;

  // Stream status codes.
  localparam logic [1:0] ST_RUNNING = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_FAIL    = 2'd2;

  // Command byte values and long count fields.
  localparam logic [7:0] CMD_FILL = 8'h00;
  localparam logic [7:0] CMD_LONG = 8'h80;
  localparam int         LONG_SKIP_BIT = 15;
  localparam int         LONG_FILL_BIT = 14;

  // One input request held in the input stage.
  typedef struct packed {
    logic [7:0] src_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  // Action decoded from one byte.
  typedef struct packed {
    logic [1:0]  action;
    logic [14:0] run_length;
    logic [7:0]  xor_value;
  } act_t;

endpackage

`default_nettype wire

### rtl/xdcd_in_stage.sv
// Input register stage of the XOR-delta command decoder.
`default_nettype none

module xdcd_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire xdcd_pkg::in_item_t in_item,
  input  wire logic              advance,
  output logic                   s1_valid,
  output xdcd_pkg::in_item_t     s1_item
);
  import xdcd_pkg::*;

  logic accept;

  // The stage takes a new request whenever it is empty or its request moves on.
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
    end
  end

endmodule

`default_nettype wire

### rtl/xdcd_decode.sv
// Combinational decode of one delta byte against the current stream state.
`default_nettype none

module xdcd_decode #(
  parameter int PW = 16
) (
  input  wire logic              [15:0]   dest_length,
  input  wire xdcd_pkg::in_item_t         item,
  input  wire xdcd_pkg::phase_t           phase,
  input  wire logic              [PW-1:0] write_pos,
  input  wire logic              [13:0]   pending_count,
  input  wire logic              [7:0]    count_low,
  input  wire logic              [1:0]    outcome,
  output xdcd_pkg::phase_t                phase_next,
  output logic                   [PW-1:0] write_pos_next,
  output logic                   [13:0]   pending_count_next,
  output logic                   [7:0]    count_low_next,
  output logic                   [1:0]    outcome_next,
  output xdcd_pkg::act_t                  act
);
  import xdcd_pkg::*;

  localparam logic [15:0] LEN_CAP = 16'((32'd1 << PW) - 32'd1);

  always_comb begin
    phase_t      ph;
    logic [PW-1:0] wp;
    logic [13:0] pc;
    logic [7:0]  cl;
    logic [1:0]  oc;
    logic [7:0]  b;
    logic [15:0] wp16;
    logic [15:0] len16;
    logic [15:0] room16;
    logic [15:0] n_long;
    logic [15:0] skip_n;
    logic [15:0] fill_n;
    logic [15:0] fill_r;
    logic [15:0] lit_n;
    logic [15:0] wp_inc;
    logic [7:0]  fill_v;
    logic        do_skip;
    logic        do_fill;
    logic        do_lit;

    // A first byte restarts the stream before it is decoded.
    b  = item.src_byte;
    ph = item.first_byte ? PH_CMD : phase;
    wp = item.first_byte ? '0 : write_pos;
    pc = item.first_byte ? '0 : pending_count;
    cl = item.first_byte ? '0 : count_low;
    oc = item.first_byte ? ST_RUNNING : outcome;

    phase_next         = ph;
    write_pos_next     = wp;
    pending_count_next = pc;
    count_low_next     = cl;
    outcome_next       = oc;
    act                = '0;

    do_skip = 1'b0;
    do_fill = 1'b0;
    do_lit  = 1'b0;
    skip_n  = '0;
    fill_n  = '0;
    fill_v  = '0;
    lit_n   = '0;
    n_long  = {b, cl};

    // Usable length and the room left behind the write position.
    len16  = (dest_length > LEN_CAP) ? LEN_CAP : dest_length;
    wp16   = 16'(wp);
    room16 = (wp16 < len16) ? (len16 - wp16) : 16'd0;
    wp_inc = wp16 + 16'd1;
    fill_r = '0;

    if (oc == ST_RUNNING) begin
      if (len16 == 16'd0) begin
        outcome_next = ST_FAIL;
      end else begin
        // Phase decode; skip, fill and literal starts are finished below.
        unique case (ph)
          PH_CMD: begin
            if (b == CMD_FILL) begin
              phase_next = PH_SF_COUNT;
            end else if (b == CMD_LONG) begin
              phase_next = PH_LONG_LO;
            end else if (b[7]) begin
              do_skip = 1'b1;
              skip_n  = {9'd0, b[6:0]};
            end else begin
              do_lit = 1'b1;
              lit_n  = {8'd0, b};
            end
          end
          PH_SF_COUNT: begin
            count_low_next = b;
            phase_next     = PH_SF_VALUE;
          end
          PH_SF_VALUE: begin
            do_fill = 1'b1;
            fill_n  = {8'd0, cl};
            fill_v  = b;
          end
          PH_LONG_LO: begin
            count_low_next = b;
            phase_next     = PH_LONG_HI;
          end
          PH_LONG_HI: begin
            if (n_long == 16'd0) begin
              outcome_next = ST_DONE;
              phase_next   = PH_CMD;
            end else if (!n_long[LONG_SKIP_BIT]) begin
              do_skip = 1'b1;
              skip_n  = n_long;
            end else if (n_long[LONG_FILL_BIT]) begin
              pending_count_next = n_long[13:0];
              phase_next         = PH_LF_VALUE;
            end else begin
              do_lit = 1'b1;
              lit_n  = {2'd0, n_long[13:0]};
            end
          end
          PH_LF_VALUE: begin
            do_fill = 1'b1;
            fill_n  = {2'd0, pc};
            fill_v  = b;
          end
          PH_LIT: begin
            if (room16 == 16'd0) begin
              outcome_next = ST_FAIL;
            end else begin
              act.action         = ACT_LIT;
              act.run_length     = 15'd1;
              act.xor_value      = b;
              write_pos_next     = PW'(wp_inc);
              pending_count_next = pc - 14'd1;
              if (pc == 14'd1) begin
                phase_next = PH_CMD;
              end else if (wp_inc >= len16) begin
                outcome_next = ST_FAIL;
              end
            end
          end
          default: begin
            outcome_next = ST_FAIL;
          end
        endcase

        // Skip: an overrun fails and leaves the position where it is.
        if (do_skip) begin
          if (skip_n > room16) begin
            outcome_next = ST_FAIL;
          end else begin
            act.action     = ACT_SKIP;
            act.run_length = skip_n[14:0];
            write_pos_next = PW'(wp16 + skip_n);
            phase_next     = PH_CMD;
          end
        end

        // Fill: clipped to the room left, an overrun fails.
        if (do_fill) begin
          fill_r = (fill_n <= room16) ? fill_n : room16;
          if (fill_r != 16'd0) begin
            act.action     = ACT_FILL;
            act.run_length = fill_r[14:0];
            act.xor_value  = fill_v;
            write_pos_next = PW'(wp16 + fill_r);
          end
          if (fill_n > room16) begin
            outcome_next = ST_FAIL;
          end
          phase_next = PH_CMD;
        end

        // Literal run start; an empty run does nothing.
        if (do_lit) begin
          if (lit_n == 16'd0) begin
            phase_next = PH_CMD;
          end else begin
            pending_count_next = lit_n[13:0];
            phase_next         = PH_LIT;
            if (room16 == 16'd0) begin
              outcome_next = ST_FAIL;
            end
          end
        end
      end

      // A stream still running on its last source byte has ended early.
      if ((outcome_next == ST_RUNNING) && item.last_byte) begin
        outcome_next = ST_FAIL;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/xor_delta_command_decoder.sv
// Top level of the XOR-delta command decoder: state, result register and checks.
//
// Usage:
//   Delta bytes enter on the input channel (in_valid / in_stall) with src_byte,
//   first_byte (restart the stream before this byte) and last_byte (final byte).
//   Every accepted byte yields exactly one result on the output channel
//   (out_valid / out_stall): action, start_pos, run_length, xor_value, status.
//   dest_length is written through the cfg_valid / cfg_ready port, which is
//   always ready; write it only while no request is in flight.
//   A byte accepted on the input channel is held in the input register, and its
//   result is then registered in the result register, from which it is taken
//   on the output channel.
//   Throughput: one byte per cycle while out_stall is low; the whole decode
//   of a byte and the stream state update sit between input and result registers.
//   When the receiver stalls, the result register holds; the input register
//   takes one more byte only if it is empty, and in_stall is high while it
//   holds a byte, until the result moves on.
//   Reset clears both registers' valid flags, the stream state (command phase,
//   position zero, running) and dest_length to zero.
`default_nettype none

module xor_delta_command_decoder #(
  parameter int POS_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] dest_length,
  // Input channel.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  src_byte,
  input  wire logic        first_byte,
  input  wire logic        last_byte,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       action,
  output logic [15:0]      start_pos,
  output logic [14:0]      run_length,
  output logic [7:0]       xor_value,
  output logic [1:0]       status
);
  import xdcd_pkg::*;

  // The position never exceeds the 16-bit length, nor the configured cap.
  localparam int PW = (POS_BITS < 16) ? POS_BITS : 16;

  in_item_t      in_item;
  in_item_t      s1_item;
  logic          s1_valid;
  logic          advance;
  logic [15:0]   dest_length_q;

  phase_t        phase;
  phase_t        phase_next;
  logic [PW-1:0] write_pos;
  logic [PW-1:0] write_pos_next;
  logic [13:0]   pending_count;
  logic [13:0]   pending_count_next;
  logic [7:0]    count_low;
  logic [7:0]    count_low_next;
  logic [1:0]    outcome;
  logic [1:0]    outcome_next;
  act_t          act;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_length_q <= '0;
    end else if (cfg_valid && cfg_ready) begin
      dest_length_q <= dest_length;
    end
  end

  // Input stage.
  assign in_item.src_byte   = src_byte;
  assign in_item.first_byte = first_byte;
  assign in_item.last_byte  = last_byte;

  assign advance = s1_valid && (!out_valid || !out_stall);

  xdcd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // Decode of the held byte.
  xdcd_decode #(
    .PW (PW)
  ) u_decode (
    .dest_length        (dest_length_q),
    .item               (s1_item),
    .phase              (phase),
    .write_pos          (write_pos),
    .pending_count      (pending_count),
    .count_low          (count_low),
    .outcome            (outcome),
    .phase_next         (phase_next),
    .write_pos_next     (write_pos_next),
    .pending_count_next (pending_count_next),
    .count_low_next     (count_low_next),
    .outcome_next       (outcome_next),
    .act                (act)
  );

  // Stream state, updated as each request moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_CMD;
      write_pos     <= '0;
      pending_count <= '0;
      count_low     <= '0;
      outcome       <= ST_RUNNING;
    end else if (advance) begin
      phase         <= phase_next;
      write_pos     <= write_pos_next;
      pending_count <= pending_count_next;
      count_low     <= count_low_next;
      outcome       <= outcome_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      action     <= act.action;
      start_pos  <= s1_item.first_byte ? 16'd0 : 16'(write_pos);
      run_length <= act.run_length;
      xor_value  <= act.xor_value;
      status     <= outcome_next;
    end
  end

  // Once a stream has ended, bytes until the next restart give no action.
  a_ended_no_action: assert property (@(posedge clk) disable iff (rst)
    advance && !s1_item.first_byte && (outcome != ST_RUNNING) |=> action == ACT_NONE)
    else $error("action reported after the stream ended");

  // The input stage only stalls while it holds a request.
  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty input register");

  // A literal result always covers exactly one byte.
  a_literal_one_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_LIT) |-> run_length == 15'd1)
    else $error("literal result with a run length other than one");

  // A running stream cannot decode a byte after its last byte.
  a_last_ends_stream: assert property (@(posedge clk) disable iff (rst)
    advance && s1_item.last_byte |=> status != ST_RUNNING)
    else $error("stream still running after its last byte");

endmodule

`default_nettype wire
